// ===== src/ground_plane_homography_map_assert.svh =====
// Assertion macros used by the homography map design file.
`ifndef GROUND_PLANE_HOMOGRAPHY_MAP_ASSERT_SVH
`define GROUND_PLANE_HOMOGRAPHY_MAP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define GPHM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define GPHM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/gphm_pkg.sv =====
// Shared types and constants of the ground-plane homography map.
`default_nettype none
package gphm_pkg;

	// Configuration port widths and register indexes.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 63;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0 = 8'd0,
		REG_ROW1 = 8'd1,
		REG_ROW2 = 8'd2,
		REG_MODE = 8'd3
	} gphm_reg_t;

	// Result status; zero divisor wins over horizon, horizon over saturation.
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_HORIZON = 2'd1,
		STAT_ZERO    = 2'd2,
		STAT_SAT     = 2'd3
	} gphm_status_t;

	// Flags that travel beside the data through the pipeline.
	typedef struct packed {
		logic xneg;
		logic yneg;
		logic zero;
		logic inv;
		logic ovx;
		logic ovy;
	} gphm_side_t;

endpackage
`default_nettype wire

// ===== src/gphm_point_if.sv =====
// Input point channel.
`default_nettype none
interface gphm_point_if #(parameter int COORD_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface
`default_nettype wire

// ===== src/gphm_result_if.sv =====
// Mapped point result channel.
`default_nettype none
interface gphm_result_if #(parameter int COORD_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] mapped_x;
	logic signed [COORD_BITS-1:0] mapped_y;
	logic [1:0]                   map_status;

	modport source (output valid, output mapped_x, output mapped_y, output map_status,
		input ready);
	modport sink (input valid, input mapped_x, input mapped_y, input map_status,
		output ready);
endinterface
`default_nettype wire

// ===== src/gphm_cfg_if.sv =====
// Configuration write channel.
`default_nettype none
interface gphm_cfg_if;
	import gphm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/ground_plane_homography_map.sv =====
// Ground-plane homography point map: matrix multiply, perspective divide, saturation.
//
// Maps one point per clock through a 3x3 homography with perspective divide. Its stages are
// one of products, one of row sums, one of sign and magnitude, one of scaling and overflow
// check, one restoring-divider stage per quotient bit, and one of clamping and status.
// Throughput is one point per cycle; each stage holds only while the stage after it is full
// and blocked, so a waiting result does not stop new points from filling empty stages.
// Configuration writes are always taken and should be made while no point is in flight.
`default_nettype none
`include "ground_plane_homography_map_assert.svh"
module ground_plane_homography_map #(
	parameter int COEF_BITS  = 21,
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	gphm_cfg_if.sink           cfg,
	gphm_point_if.sink         point,
	gphm_result_if.source      mapped
);
	import gphm_pkg::*;

	localparam int PW   = COEF_BITS + COORD_BITS;
	localparam int SUMW = PW + 2;
	localparam int W    = SUMW + COORD_BITS;
	localparam int CW   = 3 * COEF_BITS;
	localparam int NS   = COORD_BITS + 5;
	localparam int C    = COORD_BITS;

	// Configuration registers.
	logic [CW-1:0] row_q [3];
	logic          mode_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= CW'(1);
			row_q[1] <= CW'(1) << COEF_BITS;
			row_q[2] <= CW'(1) << (2 * COEF_BITS);
			mode_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ROW0: row_q[0] <= cfg.data[CW-1:0];
				REG_ROW1: row_q[1] <= cfg.data[CW-1:0];
				REG_ROW2: row_q[2] <= cfg.data[CW-1:0];
				REG_MODE: mode_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Stage valids and load enables; a stage loads when it is empty or its successor loads.
	logic v [1:NS];
	logic en [1:NS+1];

	always_comb begin
		en[NS+1] = mapped.ready;
		for (int s = NS; s >= 1; s--) begin
			en[s] = !v[s] || en[s+1];
		end
	end

	assign point.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= NS; s++) begin
				v[s] <= 1'b0;
			end
		end else begin
			if (en[1]) begin
				v[1] <= point.valid;
			end
			for (int s = 2; s <= NS; s++) begin
				if (en[s]) begin
					v[s] <= v[s-1];
				end
			end
		end
	end

	// Stage 1: coefficient products.
	logic signed [PW-1:0] px_s1 [3];
	logic signed [PW-1:0] py_s1 [3];
	logic signed [PW-1:0] pc_s1 [3];
	logic                 inv_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int r = 0; r < 3; r++) begin
				px_s1[r] <= PW'($signed(row_q[r][0 +: COEF_BITS]) * point.point_x);
				py_s1[r] <= PW'($signed(row_q[r][COEF_BITS +: COEF_BITS]) * point.point_y);
				pc_s1[r] <= PW'($signed(row_q[r][2*COEF_BITS +: COEF_BITS])) <<< FRAC_BITS;
			end
			inv_s1 <= mode_q;
		end
	end

	// Stage 2: row sums.
	logic signed [SUMW-1:0] nx_s2, ny_s2, dv_s2;
	logic                   inv_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			nx_s2  <= SUMW'(px_s1[0]) + SUMW'(py_s1[0]) + SUMW'(pc_s1[0]);
			ny_s2  <= SUMW'(px_s1[1]) + SUMW'(py_s1[1]) + SUMW'(pc_s1[1]);
			dv_s2  <= SUMW'(px_s1[2]) + SUMW'(py_s1[2]) + SUMW'(pc_s1[2]);
			inv_s2 <= inv_s1;
		end
	end

	// Stage 3: magnitudes and quotient signs.
	logic [SUMW-1:0] nxm_s3, nym_s3, dm_s3;
	gphm_side_t      side_s3;
	logic            dneg, xneg_c, yneg_c;

	always_comb begin
		dneg   = dv_s2 < 0;
		xneg_c = (nx_s2 != 0) && ((nx_s2 < 0) != dneg);
		yneg_c = (ny_s2 != 0) && ((ny_s2 < 0) != dneg);
		if (inv_s2) begin
			yneg_c = (ny_s2 != 0) && !yneg_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			nxm_s3  <= (nx_s2 < 0) ? SUMW'(-nx_s2) : SUMW'(nx_s2);
			nym_s3  <= (ny_s2 < 0) ? SUMW'(-ny_s2) : SUMW'(ny_s2);
			dm_s3   <= (dv_s2 < 0) ? SUMW'(-dv_s2) : SUMW'(dv_s2);
			side_s3 <= '{xneg: xneg_c, yneg: yneg_c, zero: dv_s2 == 0, inv: inv_s2,
				ovx: 1'b0, ovy: 1'b0};
		end
	end

	// Stage 4 and divider stages: scaled numerators, then one quotient bit per stage.
	logic [W-1:0]  rx_d [0:C];
	logic [W-1:0]  ry_d [0:C];
	logic [W-1:0]  d_d  [0:C];
	logic [C-1:0]  qx_d [0:C];
	logic [C-1:0]  qy_d [0:C];
	gphm_side_t    sd_d [0:C];
	logic [W-1:0]  nxs, nys, dws;
	gphm_side_t    side_d0;

	assign nxs = W'(nxm_s3) << FRAC_BITS;
	assign nys = W'(nym_s3) << FRAC_BITS;
	assign dws = W'(dm_s3);

	// Overflow when the quotient needs more than COORD_BITS bits.
	always_comb begin
		side_d0     = side_s3;
		side_d0.ovx = (nxs >> C) >= dws;
		side_d0.ovy = (nys >> C) >= dws;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			rx_d[0] <= nxs;
			ry_d[0] <= nys;
			d_d[0]  <= dws;
			qx_d[0] <= '0;
			qy_d[0] <= '0;
			sd_d[0] <= side_d0;
		end
	end

	for (genvar k = 0; k < C; k++) begin : g_div
		localparam int J = C - 1 - k;
		logic [W-1:0] dsh;
		logic         bx, by;

		assign dsh = d_d[k] << J;
		assign bx  = rx_d[k] >= dsh;
		assign by  = ry_d[k] >= dsh;

		// Restoring step for quotient bit J.
		always_ff @(posedge clk) begin
			if (en[5+k]) begin
				rx_d[k+1] <= bx ? rx_d[k] - dsh : rx_d[k];
				ry_d[k+1] <= by ? ry_d[k] - dsh : ry_d[k];
				d_d[k+1]  <= d_d[k];
				qx_d[k+1] <= qx_d[k] | (C'(bx) << J);
				qy_d[k+1] <= qy_d[k] | (C'(by) << J);
				sd_d[k+1] <= sd_d[k];
			end
		end
	end

	// Clamp a quotient magnitude to the signed range and apply its sign.
	function automatic logic [C:0] fit(input logic [C-1:0] q, input logic ov,
		input logic neg);
		logic [C-1:0] lim;
		logic [C-1:0] mq;
		logic         sat;
		lim = C'(1) << (C - 1);
		mq  = q;
		sat = 1'b0;
		if (neg) begin
			if (ov || q > lim) begin
				mq  = lim;
				sat = 1'b1;
			end
			mq = C'(0) - mq;
		end else if (ov || q >= lim) begin
			mq  = lim - C'(1);
			sat = 1'b1;
		end
		return {sat, mq};
	endfunction

	// Final stage: saturation, zero divisor and status.
	logic [C:0]         fx, fy;
	gphm_side_t         sf;
	logic signed [C-1:0] ox_s, oy_s;
	gphm_status_t       st_s;

	always_comb begin
		sf = sd_d[C];
		fx = fit(qx_d[C], sf.ovx, sf.xneg);
		fy = fit(qy_d[C], sf.ovy, sf.yneg);
		if (sf.zero) begin
			ox_s = '0;
			oy_s = '0;
			st_s = STAT_ZERO;
		end else begin
			ox_s = $signed(fx[C-1:0]);
			oy_s = $signed(fy[C-1:0]);
			if (sf.inv && sf.xneg) begin
				st_s = STAT_HORIZON;
			end else if (fx[C] || fy[C]) begin
				st_s = STAT_SAT;
			end else begin
				st_s = STAT_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			mapped.mapped_x   <= ox_s;
			mapped.mapped_y   <= oy_s;
			mapped.map_status <= st_s;
		end
	end

	assign mapped.valid = v[NS];

	// Checks on the pipeline and the result encoding.
	`GPHM_ASSERT_NOW(a_ready_full, !point.ready, v[1], "input stalled while stage one empty")
	`GPHM_ASSERT_NOW(a_zero_out, mapped.valid && mapped.map_status == STAT_ZERO,
		mapped.mapped_x == 0 && mapped.mapped_y == 0, "zero divisor with nonzero result")
	`GPHM_ASSERT_NOW(a_horizon_sign, mapped.valid && mapped.map_status == STAT_HORIZON,
		mapped.mapped_x <= 0, "above horizon with positive x")
	`GPHM_ASSERT_NOW(a_sat_limit, mapped.valid && mapped.map_status == STAT_SAT,
		mapped.mapped_x == {1'b0, {(C-1){1'b1}}} || mapped.mapped_x == {1'b1, {(C-1){1'b0}}}
		|| mapped.mapped_y == {1'b0, {(C-1){1'b1}}}
		|| mapped.mapped_y == {1'b1, {(C-1){1'b0}}}, "saturated status without limit value")
	`GPHM_ASSERT_NEXT(a_hold, mapped.valid && !mapped.ready, mapped.valid,
		"stalled result dropped")

endmodule
`default_nettype wire

// ===== sim/ground_plane_homography_map_tb.sv =====
// Self-checking testbench for the ground-plane homography point map.
`timescale 1ns / 100ps
`default_nettype none
module ground_plane_homography_map_tb;
	import gphm_pkg::*;

	localparam int COEF_BITS  = 21;
	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 8;
	localparam int LATENCY    = COORD_BITS + 5;

	typedef struct packed {
		logic [COORD_BITS-1:0] mx;
		logic [COORD_BITS-1:0] my;
		gphm_status_t          status;
	} mapped_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gphm_cfg_if                          cfg ();
	gphm_point_if #(.COORD_BITS(COORD_BITS))  point ();
	gphm_result_if #(.COORD_BITS(COORD_BITS)) mapped ();

	ground_plane_homography_map #(
		.COEF_BITS(COEF_BITS), .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg.sink), .point(point.sink), .mapped(mapped.source)
	);

	always #5 clk = ~clk;

	// Local copy of the configuration registers.
	logic [3*COEF_BITS-1:0] row_q [3];
	logic                   inv_mode;

	mapped_pt_t expected_pts [$];
	int mismatches = 0;
	int points_sent = 0;
	int results_seen = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;

	// Sum of one row times the homogeneous point (x, y, 1).
	function automatic longint row_dot(logic [3*COEF_BITS-1:0] r, longint x, longint y);
		longint c0, c1, c2;
		c0 = longint'(signed'(r[COEF_BITS-1:0]));
		c1 = longint'(signed'(r[2*COEF_BITS-1:COEF_BITS]));
		c2 = longint'(signed'(r[3*COEF_BITS-1:2*COEF_BITS]));
		return c0 * x + c1 * y + c2 * (longint'(1) << FRAC_BITS);
	endfunction

	// Truncated quotient (n << FRAC) / d by magnitude, clamped to the coordinate range.
	function automatic logic [COORD_BITS-1:0] clamp_quot(bit neg, longint unsigned n,
			longint unsigned d, ref bit sat);
		longint unsigned lim, q0, r, q;
		lim = 64'd1 << (COORD_BITS - 1);
		q0 = n / d;
		r = n % d;
		if (q0 > (lim >> FRAC_BITS)) begin
			q = lim;
			sat = 1'b1;
		end else begin
			q = q0;
			for (int i = 0; i < FRAC_BITS; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= d) begin
					r = r - d;
					q = q | 64'd1;
				end
			end
			if (q > lim) begin
				q = lim;
				sat = 1'b1;
			end
		end
		if (!neg && q > lim - 1) begin
			q = lim - 1;
			sat = 1'b1;
		end
		if (neg)
			q = 64'd0 - q;
		return q[COORD_BITS-1:0];
	endfunction

	function automatic longint unsigned abs64(longint v);
		return (v < 0) ? longint'(0) - v : v;
	endfunction

	// Predicts the mapped point for one input point.
	function automatic mapped_pt_t map_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
		mapped_pt_t res;
		longint x, y, nx, ny, dv;
		bit sat, xneg, yneg, dneg;
		x = longint'(signed'(px));
		y = longint'(signed'(py));
		nx = row_dot(row_q[0], x, y);
		ny = row_dot(row_q[1], x, y);
		dv = row_dot(row_q[2], x, y);
		sat = 1'b0;
		if (dv == 0) begin
			res.mx = '0;
			res.my = '0;
			res.status = STAT_ZERO;
			return res;
		end
		dneg = dv < 0;
		xneg = (nx != 0) && ((nx < 0) != dneg);
		yneg = (ny != 0) && ((ny < 0) != dneg);
		if (inv_mode)
			yneg = (ny != 0) && !yneg;
		res.mx = clamp_quot(xneg, abs64(nx), abs64(dv), sat);
		res.my = clamp_quot(yneg, abs64(ny), abs64(dv), sat);
		if (inv_mode && xneg)
			res.status = STAT_HORIZON;
		else if (sat)
			res.status = STAT_SAT;
		else
			res.status = STAT_OK;
		return res;
	endfunction

	initial begin
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		point.valid = 1'b0;
		point.point_x = '0;
		point.point_y = '0;
		mapped.ready = 1'b0;
		row_q[0] = 63'd1;
		row_q[1] = 63'd1 << COEF_BITS;
		row_q[2] = 63'd1 << (2 * COEF_BITS);
		inv_mode = 1'b0;
	end

	// Receiver stall pattern: phases of always-ready, random and heavy stalling.
	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0)
				stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: mapped.ready <= 1'b1;
				1: mapped.ready <= ($urandom_range(0, 3) != 0);
				default: mapped.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Compare each result transfer against the oldest prediction.
	always @(posedge clk) begin
		mapped_pt_t got, exp_pt;
		if (arst_n && mapped.valid && mapped.ready) begin
			got.mx = mapped.mapped_x;
			got.my = mapped.mapped_y;
			got.status = gphm_status_t'(mapped.map_status);
			results_seen++;
			if (expected_pts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result x=%h y=%h st=%0d", $realtime,
						got.mx, got.my, got.status);
			end else begin
				exp_pt = expected_pts.pop_front();
				if (got !== exp_pt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp x=%h y=%h st=%0d got x=%h y=%h st=%0d",
							$realtime, exp_pt.mx, exp_pt.my, exp_pt.status,
							got.mx, got.my, got.status);
				end
			end
		end
	end

	// Write one configuration register; the block must be idle.
	task automatic write_reg(gphm_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_ROW0: row_q[0] = value[3*COEF_BITS-1:0];
			REG_ROW1: row_q[1] = value[3*COEF_BITS-1:0];
			REG_ROW2: row_q[2] = value[3*COEF_BITS-1:0];
			REG_MODE: inv_mode = value[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Send one point, with bursts and gaps on the sender side.
	task automatic send_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
		if (burst_left == 0) begin
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 20);
		end
		if (gap_left > 0) begin
			point.valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		point.valid <= 1'b1;
		point.point_x <= px;
		point.point_y <= py;
		do @(posedge clk); while (!point.ready);
		expected_pts.push_back(map_point(px, py));
		points_sent++;
		burst_left--;
	endtask

	// Wait until every prediction has been matched, then let the pipeline drain.
	task automatic drain();
		point.valid <= 1'b0;
		burst_left = 0;
		wait (expected_pts.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [3*COEF_BITS-1:0] pack_row(int c0, int c1, int c2);
		return {c2[COEF_BITS-1:0], c1[COEF_BITS-1:0], c0[COEF_BITS-1:0]};
	endfunction

	function automatic logic [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return COORD_BITS'($urandom);
			1: return COORD_BITS'($signed($urandom_range(0, 4000)) - 2000);
			2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			default: return COORD_BITS'($signed($urandom_range(0, 200000)) - 100000);
		endcase
	endfunction

	function automatic int rand_coef();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 2000)) - 1000;
			1: return $urandom_range(0, 1) ? 1048575 : -1048576;
			2: return $signed($urandom_range(0, 20)) - 10;
			default: return int'($urandom) >>> 11;
		endcase
	endfunction

	// Identity at reset, then the corner values of the coordinates.
	task automatic test_reset_identity();
		send_point(24'h000000, 24'h000000);
		send_point(24'h7fffff, 24'h800000);
		send_point(24'h800000, 24'h7fffff);
		send_point(24'hffffff, 24'h000001);
		send_point(24'h555555, 24'haaaaaa);
		drain();
	endtask

	// Zero divisor, saturation both ways, horizon and negated y in inverse mode, a negative divisor and an unused index.
	task automatic test_special_cases();
		write_reg(REG_ROW2, pack_row(0, 0, 0));
		send_point(24'h000100, 24'h000200);
		drain();
		write_reg(REG_ROW0, pack_row(1048575, 0, 0));
		write_reg(REG_ROW1, pack_row(0, -1048576, 0));
		write_reg(REG_ROW2, pack_row(0, 0, 1));
		send_point(24'h7fffff, 24'h7fffff);
		send_point(24'h800000, 24'h800000);
		send_point(24'h000001, 24'hffffff);
		drain();
		write_reg(REG_MODE, 63'h7ffffffffffffffe | 63'd1);
		write_reg(REG_ROW0, pack_row(1, 0, 0));
		write_reg(REG_ROW1, pack_row(0, 1, 0));
		write_reg(REG_ROW2, pack_row(0, 0, 3));
		send_point(24'hffffff, 24'h800000);
		send_point(24'h000001, 24'h000001);
		send_point(24'h800000, 24'h000000);
		send_point(24'h000000, 24'hfffffe);
		drain();
		write_reg(REG_ROW2, {63{1'b1}});
		send_point(24'h000010, 24'h7fffff);
		send_point(24'hffffff, 24'h000003);
		drain();
		write_reg(REG_MODE, 63'd0);
		write_reg(gphm_reg_t'(8'hff), {63{1'b1}});
		send_point(24'h001234, 24'hff0000);
		drain();
	endtask

	// Random matrices and points across both modes.
	task automatic test_random_mapping(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			write_reg(REG_ROW0, CFG_DATA_W'({$urandom, $urandom} | pack_row(rand_coef(),
				rand_coef(), rand_coef())));
			write_reg(REG_ROW0, pack_row(rand_coef(), rand_coef(), rand_coef()));
			write_reg(REG_ROW1, pack_row(rand_coef(), rand_coef(), rand_coef()));
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_ROW2, pack_row(0, 0, 0));
			else
				write_reg(REG_ROW2, pack_row(rand_coef(), rand_coef(), rand_coef()));
			write_reg(REG_MODE, CFG_DATA_W'({$urandom, $urandom}));
			for (int i = 0; i < per_phase; i++)
				send_point(rand_coord(), rand_coord());
			drain();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_identity();
		test_special_cases();
		test_random_mapping(29, 50);
		$display("Covered %0d points and %0d results over reset, corner and random matrices,",
			points_sent, results_seen);
		$display("both mapping modes, zero divisors and saturation.");
		if (mismatches == 0 && expected_pts.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout reached");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
